### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that hold in every cycle.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that hold in the same cycle as the trigger.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that hold in the cycle after the trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/rm_pkg.sv
package rm_pkg;

	typedef logic [1:0] op_t;

	localparam op_t OP_HOLD    = 2'd0;
	localparam op_t OP_INS     = 2'd1;
	localparam op_t OP_INS_POP = 2'd2;
	localparam op_t OP_PUSH    = 2'd3;

endpackage

### hdl/rm_in_if.sv
interface rm_in_if #(
	parameter int VALUE_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

### hdl/rm_out_if.sv
interface rm_out_if #(
	parameter int VALUE_BITS = 32,
	parameter int TOTAL_BITS = 11
);
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_BITS:0] median_twice;
	logic [TOTAL_BITS-1:0]      stored_total;
	logic                       dropped;

	modport source (output valid, output median_twice, output stored_total, output dropped,
		input ready);
	modport sink (input valid, input median_twice, input stored_total, input dropped,
		output ready);
endinterface

### hdl/rm_cell.sv
module rm_cell #(
	parameter int W    = 32,
	parameter bit DESC = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rm_pkg::op_t         op,
	input  logic signed [W-1:0] v,
	input  logic signed [W-1:0] l_val,
	input  logic                l_vld,
	input  logic                l_b,
	input  logic signed [W-1:0] r_val,
	input  logic                r_b,
	output logic signed [W-1:0] val,
	output logic                vld,
	output logic                b
);

	logic signed [W-1:0] val_q;
	logic signed [W-1:0] val_d;
	logic                vld_q;
	logic                vld_d;

	// The flag b marks an entry that stays ahead of the new sample.
	assign b   = vld_q && (DESC ? (val_q >= v) : (val_q <= v));
	assign val = val_q;
	assign vld = vld_q;

	always_comb begin
		val_d = val_q;
		vld_d = vld_q;
		case (op)
			rm_pkg::OP_INS: begin
				val_d = b ? val_q : (l_b ? v : l_val);
				vld_d = vld_q | l_vld;
			end
			rm_pkg::OP_INS_POP: begin
				val_d = r_b ? r_val : (b ? v : val_q);
				vld_d = vld_q;
			end
			rm_pkg::OP_PUSH: begin
				val_d = l_val;
				vld_d = l_vld;
			end
			default: begin
				val_d = val_q;
				vld_d = vld_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

### hdl/rm_chain.sv
`include "assert_macros.svh"

module rm_chain #(
	parameter int N    = 512,
	parameter int W    = 32,
	parameter bit DESC = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rm_pkg::op_t         op,
	input  logic signed [W-1:0] v,
	input  logic signed [W-1:0] push_val,
	output logic signed [W-1:0] top_val,
	output logic signed [W-1:0] pop_val
);

	logic signed [W-1:0] cv [0:N+1];
	logic [N+1:0]        cvld;
	logic [N+1:0]        cb;
	logic [N-1:0]        vmask;

	// Index 0 and index N+1 are the fixed neighbors at both ends of the row.
	assign cv[0]     = push_val;
	assign cvld[0]   = 1'b1;
	assign cb[0]     = 1'b1;
	assign cv[N+1]   = push_val;
	assign cvld[N+1] = 1'b0;
	assign cb[N+1]   = 1'b0;

	for (genvar i = 1; i <= N; i++) begin : g_cell
		rm_cell #(
			.W    (W),
			.DESC (DESC)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op),
			.v      (v),
			.l_val  (cv[i-1]),
			.l_vld  (cvld[i-1]),
			.l_b    (cb[i-1]),
			.r_val  (cv[i+1]),
			.r_b    (cb[i+1]),
			.val    (cv[i]),
			.vld    (cvld[i]),
			.b      (cb[i])
		);
	end

	assign top_val = cv[1];
	assign pop_val = cb[1] ? cv[1] : v;
	assign vmask   = cvld[N:1];

	`ASSERT_ALWAYS(a_valid_prefix, ((vmask + N'(1)) & vmask) == '0,
		"Occupied cells do not form a prefix of the row.")
	`ASSERT_NEXT(a_insert_fills_top, op == rm_pkg::OP_INS, cvld[1],
		"Head cell is empty after an insert.")
	`ASSERT_NEXT(a_push_lands_top, op == rm_pkg::OP_PUSH, cvld[1] && cv[1] == $past(push_val),
		"Pushed entry did not land in the head cell.")

endmodule

### hdl/running_median_core.sv
// Running median over every sample accepted since reset. Samples are kept in two rows of
// compare-and-shift cells: the lower half in descending order and the upper half in ascending
// order, so that the two middle values always sit in the head cells. Each request inserts its
// sample into one row and, when needed, moves one head entry to the other row, all in the
// accepting cycle; one request is taken every cycle while the output is not stalled, and its
// result is registered. median_twice is twice the median (its lowest bit is the .5 fraction),
// stored_total counts the held samples, and once CAPACITY samples are held further samples are
// discarded with dropped set and the median repeated. No clearing pass runs after reset.
`include "assert_macros.svh"

module running_median_core #(
	parameter int CAPACITY   = 1024,
	parameter int VALUE_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	rm_in_if.sink      samples,
	rm_out_if.source   results
);

	localparam int W      = VALUE_BITS;
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int N_LOW  = (CAPACITY + 1) / 2;
	localparam int N_HIGH = (CAPACITY / 2 > 0) ? CAPACITY / 2 : 1;

	logic [CW-1:0]       n_q;
	logic                in_fire;
	logic                full;
	logic signed [W-1:0] v;
	logic signed [W-1:0] lo_top;
	logic signed [W-1:0] hi_top;
	logic signed [W-1:0] lo_pop;
	logic signed [W-1:0] hi_pop;
	logic signed [W-1:0] lo_push;
	logic signed [W-1:0] hi_push;
	rm_pkg::op_t         lo_op;
	rm_pkg::op_t         hi_op;

	logic                vld_s1;
	logic                drop_s1;
	logic                out_vld_q;
	logic                out_load;
	logic signed [W:0]   median_q;
	logic [CW-1:0]       total_q;
	logic                dropped_q;
	logic signed [W:0]   median_d;

	assign v        = samples.value;
	assign full     = n_q == CW'(CAPACITY);
	assign in_fire  = samples.valid && samples.ready;
	assign out_load = vld_s1 && (!out_vld_q || results.ready);

	assign samples.ready = !vld_s1 || out_load;

	// An even count grows the lower half, an odd count grows the upper half.
	always_comb begin
		lo_op   = rm_pkg::OP_HOLD;
		hi_op   = rm_pkg::OP_HOLD;
		lo_push = hi_pop;
		hi_push = lo_pop;
		if (in_fire && !full) begin
			if (!n_q[0]) begin
				if (n_q == '0 || v <= hi_top) begin
					lo_op = rm_pkg::OP_INS;
				end else begin
					hi_op = rm_pkg::OP_INS_POP;
					lo_op = rm_pkg::OP_PUSH;
				end
			end else begin
				if (v >= lo_top) begin
					hi_op = rm_pkg::OP_INS;
				end else begin
					lo_op = rm_pkg::OP_INS_POP;
					hi_op = rm_pkg::OP_PUSH;
				end
			end
		end
	end

	rm_chain #(
		.N    (N_LOW),
		.W    (W),
		.DESC (1'b1)
	) u_low (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (lo_op),
		.v        (v),
		.push_val (lo_push),
		.top_val  (lo_top),
		.pop_val  (lo_pop)
	);

	rm_chain #(
		.N    (N_HIGH),
		.W    (W),
		.DESC (1'b0)
	) u_high (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (hi_op),
		.v        (v),
		.push_val (hi_push),
		.top_val  (hi_top),
		.pop_val  (hi_pop)
	);

	always_comb begin
		if (n_q[0]) begin
			median_d = {lo_top, 1'b0};
		end else begin
			median_d = {lo_top[W-1], lo_top} + {hi_top[W-1], hi_top};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_fire && !full) begin
				n_q <= n_q + CW'(1);
			end
			if (in_fire) begin
				vld_s1 <= 1'b1;
			end else if (out_load) begin
				vld_s1 <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			drop_s1 <= full;
		end
		if (out_load) begin
			median_q  <= median_d;
			total_q   <= n_q;
			dropped_q <= drop_s1;
		end
	end

	assign results.valid        = out_vld_q;
	assign results.median_twice = median_q;
	assign results.stored_total = total_q;
	assign results.dropped      = dropped_q;

	`ASSERT_ALWAYS(a_count_bound, n_q <= CW'(CAPACITY),
		"Stored count is above capacity.")
	`ASSERT_NEXT(a_count_step, in_fire && !full, n_q == $past(n_q) + CW'(1),
		"Stored count did not advance after an insert.")
	`ASSERT_IMPLIES(a_drop_only_full, results.valid && results.dropped,
		results.stored_total == CW'(CAPACITY),
		"A sample was dropped while the store had room.")
	`ASSERT_IMPLIES(a_stall_blocks_input, vld_s1 && !out_load, !samples.ready,
		"Input was offered while a result could not advance.")

endmodule

### bench/tb_running_median_core.sv
module tb_running_median_core;

	localparam int CAPACITY    = 1024;
	localparam int VALUE_BITS  = 32;
	localparam int TOTAL_BITS  = 11;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int OVERFLOW_ITEMS = 580;

	localparam logic signed [VALUE_BITS-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
	localparam logic signed [VALUE_BITS-1:0] SAMPLE_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [VALUE_BITS:0] median_twice;
		logic [TOTAL_BITS-1:0]      stored_total;
		logic                       dropped;
	} median_result_t;

	logic clk;
	logic arst_n;

	rm_in_if #(.VALUE_BITS(VALUE_BITS)) samples_bus ();
	rm_out_if #(.VALUE_BITS(VALUE_BITS), .TOTAL_BITS(TOTAL_BITS)) results_bus ();

	running_median_core #(
		.CAPACITY(CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_bus),
		.results(results_bus)
	);

	logic signed [VALUE_BITS-1:0] sorted_samples[$];
	median_result_t pending_medians[$];
	int mismatch_count;
	int stall_cycles;
	int send_idle_pct;
	int recv_idle_pct;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		results_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void record_sample(logic signed [VALUE_BITS-1:0] sample);
		median_result_t r;
		int pos;
		int n;
		logic signed [VALUE_BITS:0] lo;
		logic signed [VALUE_BITS:0] hi;
		r.dropped = 1'b1;
		if (sorted_samples.size() < CAPACITY) begin
			pos = sorted_samples.size();
			while (pos > 0 && sorted_samples[pos-1] > sample)
				pos--;
			sorted_samples.insert(pos, sample);
			r.dropped = 1'b0;
		end
		n = sorted_samples.size();
		hi = sorted_samples[n/2];
		lo = (n % 2 == 1) ? hi : sorted_samples[n/2 - 1];
		r.median_twice = lo + hi;
		r.stored_total = n[TOTAL_BITS-1:0];
		pending_medians.push_back(r);
	endfunction

	function automatic logic signed [VALUE_BITS-1:0] pick_sample();
		int n;
		n = sorted_samples.size();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return SAMPLE_MAX;
					1: return SAMPLE_MIN;
					2: return -32'sd1;
					3: return 32'sd0;
					default: return 32'sd1;
				endcase
			end
			1, 2: return $signed(32'($urandom_range(16))) - 32'sd8;
			3: begin
				if (n == 0)
					return $urandom;
				return sorted_samples[n/2] + $signed(32'($urandom_range(4))) - 32'sd2;
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_sample(input logic signed [VALUE_BITS-1:0] sample);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			samples_bus.valid <= 1'b0;
			@(negedge clk);
		end
		samples_bus.valid <= 1'b1;
		samples_bus.value <= sample;
		@(posedge clk);
		while (!samples_bus.ready)
			@(posedge clk);
		record_sample(sample);
	endtask

	task automatic set_idling(input int phase);
		case (phase)
			0: begin
				send_idle_pct = 18;
				recv_idle_pct = 86;
			end
			1: begin
				send_idle_pct = 86;
				recv_idle_pct = 18;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	task automatic test_directed_edges();
		logic signed [VALUE_BITS-1:0] edge_samples[$];
		edge_samples = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
			SAMPLE_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sh5555_5555,
			32'shaaaa_aaaa, 32'sh8000_0001, 32'sh7fff_fffe, -32'sd2, 32'sd2};
		set_idling(0);
		foreach (edge_samples[i])
			send_sample(edge_samples[i]);
	endtask

	task automatic test_random_fill();
		int fill_items;
		fill_items = CAPACITY - sorted_samples.size();
		for (int i = 0; i < fill_items; i++) begin
			set_idling(i * 3 / fill_items);
			send_sample(pick_sample());
		end
	endtask

	task automatic test_full_store();
		for (int i = 0; i < OVERFLOW_ITEMS; i++) begin
			set_idling(i * 3 / OVERFLOW_ITEMS);
			send_sample(pick_sample());
		end
	endtask

	function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %0h, got %0h", field, want, got);
	endfunction

	always @(posedge clk) begin
		median_result_t want;
		if (arst_n && results_bus.valid && results_bus.ready) begin
			if (pending_medians.size() == 0) begin
				note_mismatch("unrequested result", 64'd0, 64'($signed(results_bus.median_twice)));
			end else begin
				want = pending_medians.pop_front();
				if (results_bus.median_twice !== want.median_twice)
					note_mismatch("median_twice", 64'(want.median_twice),
						64'(results_bus.median_twice));
				if (results_bus.stored_total !== want.stored_total)
					note_mismatch("stored_total", 64'(want.stored_total),
						64'(results_bus.stored_total));
				if (results_bus.dropped !== want.dropped)
					note_mismatch("dropped", 64'(want.dropped), 64'(results_bus.dropped));
			end
		end
	end

	always @(posedge clk) begin
		if ((samples_bus.valid && samples_bus.ready) || (results_bus.valid && results_bus.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("running_median_core verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		samples_bus.valid = 1'b0;
		samples_bus.value = '0;
		results_bus.ready = 1'b0;
		mismatch_count = 0;
		stall_cycles = 0;
		set_idling(0);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_edges();
		test_random_fill();
		test_full_store();

		@(negedge clk);
		samples_bus.valid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_medians.size() == 0) begin
			$display("running_median_core verification clean");
		end else begin
			$display("running_median_core verification failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/rm_pkg.sv
hdl/rm_in_if.sv
hdl/rm_out_if.sv
hdl/rm_cell.sv
hdl/rm_chain.sv
hdl/running_median_core.sv
bench/tb_running_median_core.sv
